// File: rtl/core/acep_pkg.sv
// shared types, constants and codes for the escape sequence parser
`default_nettype none

package acep_pkg;

  // sizes
  localparam int MAX_PARAMS_DEF = 16;
  localparam int RESULT_LIMIT   = 16;
  localparam int CODE_W         = 16;
  localparam int CMD_W          = 4;
  localparam int ARG_W          = 17;

  // character codes
  localparam logic [CODE_W-1:0] CH_ESC      = 16'h001B;
  localparam logic [CODE_W-1:0] CH_SPACE    = 16'h0020;
  localparam logic [CODE_W-1:0] CH_DEL      = 16'h007F;
  localparam logic [CODE_W-1:0] CH_LBRACKET = 16'h005B;
  localparam logic [CODE_W-1:0] CH_SAVE     = 16'h0037;
  localparam logic [CODE_W-1:0] CH_RESTORE  = 16'h0038;
  localparam logic [CODE_W-1:0] CH_SEMI     = 16'h003B;
  localparam logic [CODE_W-1:0] CH_DIGIT_LO = 16'h0030;
  localparam logic [CODE_W-1:0] CH_DIGIT_HI = 16'h0039;
  localparam logic [CODE_W-1:0] CH_FINAL_LO = 16'h0040;
  localparam logic [CODE_W-1:0] CH_FINAL_HI = 16'h007E;

  // final bytes
  localparam logic [CODE_W-1:0] FIN_CUU = 16'h0041;
  localparam logic [CODE_W-1:0] FIN_CUD = 16'h0042;
  localparam logic [CODE_W-1:0] FIN_CUF = 16'h0043;
  localparam logic [CODE_W-1:0] FIN_CUB = 16'h0044;
  localparam logic [CODE_W-1:0] FIN_CHA = 16'h0047;
  localparam logic [CODE_W-1:0] FIN_CUP = 16'h0048;
  localparam logic [CODE_W-1:0] FIN_ED  = 16'h004A;
  localparam logic [CODE_W-1:0] FIN_EL  = 16'h004B;
  localparam logic [CODE_W-1:0] FIN_SU  = 16'h0053;
  localparam logic [CODE_W-1:0] FIN_SD  = 16'h0054;
  localparam logic [CODE_W-1:0] FIN_VPA = 16'h0064;
  localparam logic [CODE_W-1:0] FIN_HVP = 16'h0066;
  localparam logic [CODE_W-1:0] FIN_SGR = 16'h006D;
  localparam logic [CODE_W-1:0] FIN_SCP = 16'h0073;
  localparam logic [CODE_W-1:0] FIN_RCP = 16'h0075;

  // result command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_PRINT         = 4'd0,
    CMD_CONTROL       = 4'd1,
    CMD_SAVE          = 4'd2,
    CMD_RESTORE       = 4'd3,
    CMD_MOVE          = 4'd4,
    CMD_COLUMN        = 4'd5,
    CMD_ROW           = 4'd6,
    CMD_POSITION      = 4'd7,
    CMD_ERASE_DISPLAY = 4'd8,
    CMD_ERASE_LINE    = 4'd9,
    CMD_SGR           = 4'd10,
    CMD_SCROLL        = 4'd11
  } cmd_t;

  // controller states
  typedef enum logic [2:0] {
    ST_GROUND,
    ST_ESCAPE,
    ST_CSI,
    ST_SGR_RD,
    ST_SGR_OUT
  } state_t;

  // output register source select
  typedef enum logic [2:0] {
    OSEL_TEXT,
    OSEL_SAVE,
    OSEL_RESTORE,
    OSEL_DISPATCH,
    OSEL_SGR
  } osel_t;

  // controller to datapath
  typedef struct packed {
    logic  acc_digit;
    logic  push;
    logic  clear;
    logic  out_load;
    osel_t out_sel;
    logic  sgr_start;
    logic  sgr_next;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic code_zero;
    logic is_esc;
    logic is_lbracket;
    logic is_save;
    logic is_restore;
    logic is_digit;
    logic is_semi;
    logic is_final;
    logic final_sgr;
    logic final_known;
    logic out_free;
    logic sgr_last;
  } dp_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/acep_if.sv
// valid/ready channel interfaces for input code words and result words
`default_nettype none

interface acep_in_if;
  logic                        valid;
  logic                        ready;
  logic [acep_pkg::CODE_W-1:0] code;

  modport source (output valid, output code, input ready);
  modport sink   (input valid, input code, output ready);
endinterface

interface acep_out_if;
  logic                              valid;
  logic                              ready;
  logic        [acep_pkg::CMD_W-1:0] cmd;
  logic signed [acep_pkg::ARG_W-1:0] arg_a;
  logic signed [acep_pkg::ARG_W-1:0] arg_b;
  logic                              last;

  modport source (output valid, output cmd, output arg_a, output arg_b, output last,
                  input ready);
  modport sink   (input valid, input cmd, input arg_a, input arg_b, input last,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/core/ansi_csi_escape_parser.sv
// Escape sequence parser: one 16-bit code word in, command words out.
// A result is in the output register in the cycle after its code word is taken;
// the first SGR word is read from the store in SGR_RD, then loaded in SGR_OUT once the output is free.
// Throughput: one code word per cycle while results are drained; an SGR final byte
// emits one word per stored parameter, up to RESULT_LIMIT (store read, then load).
// Reset: synchronous active-low rst_n returns to ground mode and empties the output
// register; the parameter store needs no clearing.
`default_nettype none

module ansi_csi_escape_parser #(
  parameter int MAX_PARAMS = acep_pkg::MAX_PARAMS_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  acep_in_if.sink    in_ch,
  acep_out_if.source out_ch
);

  acep_pkg::ctl_cmd_t ctl;
  acep_pkg::dp_sts_t  sts;

  // sequencing
  acep_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // decode, parameter store and output register
  acep_dp #(
    .MAX_PARAMS (MAX_PARAMS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_code   (in_ch.code),
    .out_ready (out_ch.ready),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_ch.valid),
    .out_cmd   (out_ch.cmd),
    .out_arg_a (out_ch.arg_a),
    .out_arg_b (out_ch.arg_b),
    .out_last  (out_ch.last)
  );

endmodule

`default_nettype wire

// File: rtl/core/acep_dp.sv
// parser datapath: code decode, number accumulator, parameter store, output register
`default_nettype none

module acep_dp #(
  parameter int MAX_PARAMS = acep_pkg::MAX_PARAMS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic        [acep_pkg::CODE_W-1:0] in_code,
  input  wire logic                              out_ready,
  input  wire acep_pkg::ctl_cmd_t                ctl,
  output acep_pkg::dp_sts_t                      sts,
  output logic                                   out_valid,
  output logic             [acep_pkg::CMD_W-1:0] out_cmd,
  output logic signed      [acep_pkg::ARG_W-1:0] out_arg_a,
  output logic signed      [acep_pkg::ARG_W-1:0] out_arg_b,
  output logic                                   out_last
);

  localparam int CNT_W = $clog2(MAX_PARAMS + 1);
  localparam int AW    = $clog2(MAX_PARAMS);
  localparam int LIM_C = (MAX_PARAMS < acep_pkg::RESULT_LIMIT) ? MAX_PARAMS
                                                                 : acep_pkg::RESULT_LIMIT;
  localparam int ARG_W = acep_pkg::ARG_W;

  logic [15:0]      acc_r;
  logic [CNT_W-1:0] cnt_r;
  logic [15:0]      p0_r;
  logic [15:0]      p1_r;
  logic [AW-1:0]    idx_r;
  logic [15:0]      rd_data_r;
  logic [15:0]      mem [MAX_PARAMS];

  logic                    out_valid_r;
  acep_pkg::cmd_t          out_cmd_r;
  logic signed [ARG_W-1:0] out_arg_a_r;
  logic signed [ARG_W-1:0] out_arg_b_r;
  logic                    out_last_r;

  acep_pkg::cmd_t          out_cmd_nxt;
  logic signed [ARG_W-1:0] out_arg_a_nxt;
  logic signed [ARG_W-1:0] out_arg_b_nxt;
  logic                    out_last_nxt;

  logic [19:0]      acc_prod;
  logic [15:0]      acc_dig;
  logic             cnt_room;
  logic [CNT_W-1:0] lim;
  logic [15:0]      p0_eff;
  logic [15:0]      p1_eff;
  logic [15:0]      first_u;
  logic [15:0]      second_u;
  logic signed [ARG_W-1:0] first_s;
  logic signed [ARG_W-1:0] second_s;
  logic signed [ARG_W-1:0] raw_s;
  acep_pkg::cmd_t          disp_cmd;
  logic signed [ARG_W-1:0] disp_a;
  logic signed [ARG_W-1:0] disp_b;

  // code classification
  always_comb begin
    sts.code_zero   = (in_code == '0);
    sts.is_esc      = (in_code == acep_pkg::CH_ESC);
    sts.is_lbracket = (in_code == acep_pkg::CH_LBRACKET);
    sts.is_save     = (in_code == acep_pkg::CH_SAVE);
    sts.is_restore  = (in_code == acep_pkg::CH_RESTORE);
    sts.is_digit    = (in_code >= acep_pkg::CH_DIGIT_LO) && (in_code <= acep_pkg::CH_DIGIT_HI);
    sts.is_semi     = (in_code == acep_pkg::CH_SEMI);
    sts.is_final    = (in_code >= acep_pkg::CH_FINAL_LO) && (in_code <= acep_pkg::CH_FINAL_HI);
    sts.final_sgr   = (in_code == acep_pkg::FIN_SGR);
    sts.final_known = (in_code == acep_pkg::FIN_CUU) || (in_code == acep_pkg::FIN_CUD) ||
                      (in_code == acep_pkg::FIN_CUF) || (in_code == acep_pkg::FIN_CUB) ||
                      (in_code == acep_pkg::FIN_CHA) || (in_code == acep_pkg::FIN_VPA) ||
                      (in_code == acep_pkg::FIN_CUP) || (in_code == acep_pkg::FIN_HVP) ||
                      (in_code == acep_pkg::FIN_ED)  || (in_code == acep_pkg::FIN_EL)  ||
                      (in_code == acep_pkg::FIN_SU)  || (in_code == acep_pkg::FIN_SD)  ||
                      (in_code == acep_pkg::FIN_SCP) || (in_code == acep_pkg::FIN_RCP);
    sts.out_free    = !out_valid_r || out_ready;
    sts.sgr_last    = ((CNT_W'(idx_r) + CNT_W'(1)) == lim);
  end

  // decimal accumulate, saturating at 16 bits; digit value is the low nibble
  assign acc_prod = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {16'h0000, in_code[3:0]};
  assign acc_dig  = (|acc_prod[19:16]) ? 16'hFFFF : acc_prod[15:0];
  assign cnt_room = (cnt_r < CNT_W'(MAX_PARAMS));
  assign lim      = (cnt_r > CNT_W'(LIM_C)) ? CNT_W'(LIM_C) : cnt_r;

  // first two parameters as they stand once the pending number is pushed
  always_comb begin
    p0_eff   = (cnt_r == '0) ? acc_r : p0_r;
    p1_eff   = (cnt_r == CNT_W'(1)) ? acc_r : p1_r;
    first_u  = (p0_eff == '0) ? 16'd1 : p0_eff;
    second_u = ((cnt_r != '0) && (p1_eff != '0)) ? p1_eff : 16'd1;
    first_s  = signed'({1'b0, first_u});
    second_s = signed'({1'b0, second_u});
    raw_s    = signed'({1'b0, p0_eff});
  end

  // single-result final byte dispatch
  always_comb begin
    disp_cmd = acep_pkg::CMD_SAVE;
    disp_a   = '0;
    disp_b   = '0;
    unique case (in_code)
      acep_pkg::FIN_CUU: begin disp_cmd = acep_pkg::CMD_MOVE; disp_b = -first_s; end
      acep_pkg::FIN_CUD: begin disp_cmd = acep_pkg::CMD_MOVE; disp_b = first_s; end
      acep_pkg::FIN_CUF: begin disp_cmd = acep_pkg::CMD_MOVE; disp_a = first_s; end
      acep_pkg::FIN_CUB: begin disp_cmd = acep_pkg::CMD_MOVE; disp_a = -first_s; end
      acep_pkg::FIN_CHA: begin disp_cmd = acep_pkg::CMD_COLUMN; disp_a = first_s; end
      acep_pkg::FIN_VPA: begin disp_cmd = acep_pkg::CMD_ROW; disp_a = first_s; end
      acep_pkg::FIN_CUP, acep_pkg::FIN_HVP: begin
        disp_cmd = acep_pkg::CMD_POSITION;
        disp_a   = first_s;
        disp_b   = second_s;
      end
      acep_pkg::FIN_ED: begin disp_cmd = acep_pkg::CMD_ERASE_DISPLAY; disp_a = raw_s; end
      acep_pkg::FIN_EL: begin disp_cmd = acep_pkg::CMD_ERASE_LINE; disp_a = raw_s; end
      acep_pkg::FIN_SU: begin disp_cmd = acep_pkg::CMD_SCROLL; disp_a = first_s; end
      acep_pkg::FIN_SD: begin disp_cmd = acep_pkg::CMD_SCROLL; disp_a = -first_s; end
      acep_pkg::FIN_SCP: disp_cmd = acep_pkg::CMD_SAVE;
      acep_pkg::FIN_RCP: disp_cmd = acep_pkg::CMD_RESTORE;
      default: disp_cmd = acep_pkg::CMD_SAVE;
    endcase
  end

  // output word source select
  always_comb begin
    out_cmd_nxt   = acep_pkg::CMD_SAVE;
    out_arg_a_nxt = '0;
    out_arg_b_nxt = '0;
    out_last_nxt  = 1'b1;
    unique case (ctl.out_sel)
      acep_pkg::OSEL_TEXT: begin
        out_cmd_nxt   = ((in_code < acep_pkg::CH_SPACE) || (in_code == acep_pkg::CH_DEL))
                        ? acep_pkg::CMD_CONTROL : acep_pkg::CMD_PRINT;
        out_arg_a_nxt = signed'({1'b0, in_code});
      end
      acep_pkg::OSEL_SAVE:    out_cmd_nxt = acep_pkg::CMD_SAVE;
      acep_pkg::OSEL_RESTORE: out_cmd_nxt = acep_pkg::CMD_RESTORE;
      acep_pkg::OSEL_DISPATCH: begin
        out_cmd_nxt   = disp_cmd;
        out_arg_a_nxt = disp_a;
        out_arg_b_nxt = disp_b;
      end
      acep_pkg::OSEL_SGR: begin
        out_cmd_nxt   = acep_pkg::CMD_SGR;
        out_arg_a_nxt = signed'({1'b0, rd_data_r});
        out_arg_b_nxt = signed'(ARG_W'(cnt_r));
        out_last_nxt  = sts.sgr_last;
      end
      default: out_cmd_nxt = acep_pkg::CMD_SAVE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.clear) begin
        acc_r <= '0;
        cnt_r <= '0;
      end else if (ctl.push) begin
        acc_r <= '0;
        if (cnt_room) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end else if (ctl.acc_digit) begin
        acc_r <= acc_dig;
      end

      if (ctl.sgr_start) begin
        idx_r <= '0;
      end else if (ctl.sgr_next) begin
        idx_r <= idx_r + AW'(1);
      end

      if (ctl.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // parameter store and output word
  always_ff @(posedge clk) begin
    if (ctl.push && cnt_room) begin
      mem[cnt_r[AW-1:0]] <= acc_r;
    end
    if (ctl.push && (cnt_r == '0)) begin
      p0_r <= acc_r;
    end
    if (ctl.push && (cnt_r == CNT_W'(1))) begin
      p1_r <= acc_r;
    end
    rd_data_r <= mem[idx_r];
    if (ctl.out_load) begin
      out_cmd_r   <= out_cmd_nxt;
      out_arg_a_r <= out_arg_a_nxt;
      out_arg_b_r <= out_arg_b_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_cmd   = out_cmd_r;
  assign out_arg_a = out_arg_a_r;
  assign out_arg_b = out_arg_b_r;
  assign out_last  = out_last_r;

`ifndef NO_ASSERTIONS
  // parameter count never passes the store depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_PARAMS))
    else $error("parameter count beyond store depth");

  // a new word never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |-> (!out_valid_r || out_ready))
    else $error("output word overwritten while pending");
`endif

endmodule

`default_nettype wire

// File: rtl/core/acep_ctrl.sv
// parser controller: ground, escape and csi modes plus sgr emission sequencing
`default_nettype none

module acep_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire acep_pkg::dp_sts_t sts,
  output acep_pkg::ctl_cmd_t     ctl
);

  acep_pkg::state_t state_r;
  acep_pkg::state_t state_nxt;
  logic             accepting;
  logic             in_fire;
  logic             take;

  // input side handshake; a word is only taken when the output register can hold a result
  assign accepting = (state_r == acep_pkg::ST_GROUND) || (state_r == acep_pkg::ST_ESCAPE) ||
                     (state_r == acep_pkg::ST_CSI);
  assign in_ready  = accepting && sts.out_free;
  assign in_fire   = in_valid && in_ready;
  assign take      = in_fire && !sts.code_zero;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= acep_pkg::ST_GROUND;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      acep_pkg::ST_GROUND: begin
        if (take && sts.is_esc) begin
          state_nxt = acep_pkg::ST_ESCAPE;
        end
      end
      acep_pkg::ST_ESCAPE: begin
        if (take) begin
          state_nxt = sts.is_lbracket ? acep_pkg::ST_CSI : acep_pkg::ST_GROUND;
        end
      end
      acep_pkg::ST_CSI: begin
        if (take && !sts.is_digit && !sts.is_semi) begin
          state_nxt = (sts.is_final && sts.final_sgr) ? acep_pkg::ST_SGR_RD
                                                      : acep_pkg::ST_GROUND;
        end
      end
      acep_pkg::ST_SGR_RD: state_nxt = acep_pkg::ST_SGR_OUT;
      acep_pkg::ST_SGR_OUT: begin
        if (sts.out_free) begin
          state_nxt = sts.sgr_last ? acep_pkg::ST_GROUND : acep_pkg::ST_SGR_RD;
        end
      end
      default: state_nxt = acep_pkg::ST_GROUND;
    endcase
  end

  // datapath commands
  always_comb begin
    ctl.acc_digit = 1'b0;
    ctl.push      = 1'b0;
    ctl.clear     = 1'b0;
    ctl.out_load  = 1'b0;
    ctl.out_sel   = acep_pkg::OSEL_TEXT;
    ctl.sgr_start = 1'b0;
    ctl.sgr_next  = 1'b0;
    unique case (state_r)
      acep_pkg::ST_GROUND: begin
        if (take && !sts.is_esc) begin
          ctl.out_load = 1'b1;
          ctl.out_sel  = acep_pkg::OSEL_TEXT;
        end
      end
      acep_pkg::ST_ESCAPE: begin
        if (take) begin
          if (sts.is_lbracket) begin
            ctl.clear = 1'b1;
          end else if (sts.is_save) begin
            ctl.out_load = 1'b1;
            ctl.out_sel  = acep_pkg::OSEL_SAVE;
          end else if (sts.is_restore) begin
            ctl.out_load = 1'b1;
            ctl.out_sel  = acep_pkg::OSEL_RESTORE;
          end
        end
      end
      acep_pkg::ST_CSI: begin
        if (take) begin
          priority if (sts.is_digit) begin
            ctl.acc_digit = 1'b1;
          end else if (sts.is_semi) begin
            ctl.push = 1'b1;
          end else if (sts.is_final && sts.final_sgr) begin
            // store the pending number, then walk the store
            ctl.push      = 1'b1;
            ctl.sgr_start = 1'b1;
          end else if (sts.is_final && sts.final_known) begin
            // pending number is forwarded into the dispatch word
            ctl.out_load = 1'b1;
            ctl.out_sel  = acep_pkg::OSEL_DISPATCH;
            ctl.clear    = 1'b1;
          end else begin
            ctl.clear = 1'b1;
          end
        end
      end
      acep_pkg::ST_SGR_RD: begin
        ctl.out_sel = acep_pkg::OSEL_SGR;
      end
      acep_pkg::ST_SGR_OUT: begin
        ctl.out_sel = acep_pkg::OSEL_SGR;
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          if (sts.sgr_last) begin
            ctl.clear = 1'b1;
          end else begin
            ctl.sgr_next = 1'b1;
          end
        end
      end
      default: ctl.out_sel = acep_pkg::OSEL_TEXT;
    endcase
  end

`ifndef NO_ASSERTIONS
  // no input is taken while sgr words are being produced
  a_sgr_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == acep_pkg::ST_SGR_RD) || (state_r == acep_pkg::ST_SGR_OUT)) |-> !in_ready)
    else $error("input accepted during sgr emission");

  // sgr final byte starts the store walk
  a_sgr_entry: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == acep_pkg::ST_CSI) && take && sts.is_final && sts.final_sgr)
      |=> (state_r == acep_pkg::ST_SGR_RD))
    else $error("sgr final byte did not start emission");

  // the last sgr word returns the parser to ground
  a_sgr_exit: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == acep_pkg::ST_SGR_OUT) && sts.out_free && sts.sgr_last)
      |=> (state_r == acep_pkg::ST_GROUND))
    else $error("sgr emission did not end in ground");
`endif

endmodule

`default_nettype wire

// File: tb/acep_cmd_checker.sv
// command word checker: predicts parser output from taken code words and compares
module acep_cmd_checker #(
  parameter int MAX_PARAMS = acep_pkg::MAX_PARAMS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  acep_in_if          in_ch,
  acep_out_if         out_ch,
  output int          errors,
  output int          pending,
  output int          words_in,
  output int          words_out,
  output logic [11:0] kinds_seen
);
  import acep_pkg::*;

  typedef struct packed {
    cmd_t                    cmd;
    logic signed [ARG_W-1:0] arg_a;
    logic signed [ARG_W-1:0] arg_b;
    logic                    last;
  } cmd_word_t;

  // expected command words, oldest first
  cmd_word_t cmd_q[$];

  // parser state as the predictor sees it
  state_t            mode;
  logic [CODE_W-1:0] params[MAX_PARAMS];
  int                n_params;
  int                acc;
  logic              got_digit;

  task automatic report(input string what, input int got, input int want_v);
    if (errors < 40) begin
      $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want_v);
    end
    errors++;
  endtask

  task automatic emit(input cmd_t cmd, input int a, input int b, input logic last);
    cmd_word_t w;
    w.cmd   = cmd;
    w.arg_a = a[ARG_W-1:0];
    w.arg_b = b[ARG_W-1:0];
    w.last  = last;
    cmd_q.push_back(w);
  endtask

  task automatic clear_csi();
    n_params  = 0;
    acc       = 0;
    got_digit = 1'b0;
  endtask

  // store the pending number unless the parameter list is full
  task automatic push_param();
    if (n_params < MAX_PARAMS) begin
      params[n_params] = got_digit ? acc[CODE_W-1:0] : '0;
      n_params++;
    end
    acc       = 0;
    got_digit = 1'b0;
  endtask

  // one code word through the parser, expected command words queued
  task automatic parse_code(input logic [CODE_W-1:0] c);
    int first, second, raw, lim;
    if (c == '0) return;
    case (mode)
      ST_GROUND: begin
        if (c == CH_ESC) mode = ST_ESCAPE;
        else if (c < CH_SPACE || c == CH_DEL) emit(CMD_CONTROL, int'(c), 0, 1'b1);
        else emit(CMD_PRINT, int'(c), 0, 1'b1);
      end
      ST_ESCAPE: begin
        mode = ST_GROUND;
        if (c == CH_LBRACKET) begin
          clear_csi();
          mode = ST_CSI;
        end else if (c == CH_SAVE) begin
          emit(CMD_SAVE, 0, 0, 1'b1);
        end else if (c == CH_RESTORE) begin
          emit(CMD_RESTORE, 0, 0, 1'b1);
        end
      end
      default: begin
        if (c >= CH_DIGIT_LO && c <= CH_DIGIT_HI) begin
          // decimal digit, saturating at the top of 16 bits
          acc = acc * 10 + int'(c - CH_DIGIT_LO);
          if (acc > 65535) acc = 65535;
          got_digit = 1'b1;
        end else if (c == CH_SEMI) begin
          push_param();
        end else if (c >= CH_FINAL_LO && c <= CH_FINAL_HI) begin
          push_param();
          mode   = ST_GROUND;
          first  = 1;
          second = 1;
          raw    = 0;
          if (n_params > 0) begin
            raw   = int'(params[0]);
            first = (raw == 0) ? 1 : raw;
          end
          if (n_params > 1 && params[1] != '0) second = int'(params[1]);
          case (c)
            FIN_CUU: emit(CMD_MOVE, 0, -first, 1'b1);
            FIN_CUD: emit(CMD_MOVE, 0, first, 1'b1);
            FIN_CUF: emit(CMD_MOVE, first, 0, 1'b1);
            FIN_CUB: emit(CMD_MOVE, -first, 0, 1'b1);
            FIN_CHA: emit(CMD_COLUMN, first, 0, 1'b1);
            FIN_VPA: emit(CMD_ROW, first, 0, 1'b1);
            FIN_CUP, FIN_HVP: emit(CMD_POSITION, first, second, 1'b1);
            FIN_ED:  emit(CMD_ERASE_DISPLAY, raw, 0, 1'b1);
            FIN_EL:  emit(CMD_ERASE_LINE, raw, 0, 1'b1);
            FIN_SU:  emit(CMD_SCROLL, first, 0, 1'b1);
            FIN_SD:  emit(CMD_SCROLL, -first, 0, 1'b1);
            FIN_SCP: emit(CMD_SAVE, 0, 0, 1'b1);
            FIN_RCP: emit(CMD_RESTORE, 0, 0, 1'b1);
            FIN_SGR: begin
              // one word per stored parameter, capped
              if (n_params == 0) begin
                emit(CMD_SGR, 0, 0, 1'b1);
              end else begin
                lim = (n_params > RESULT_LIMIT) ? RESULT_LIMIT : n_params;
                for (int i = 0; i < lim; i++) begin
                  emit(CMD_SGR, int'(params[i]), n_params, i == lim - 1);
                end
              end
            end
            default: ;
          endcase
          clear_csi();
        end else begin
          // anything else cancels the sequence
          clear_csi();
          mode = ST_GROUND;
        end
      end
    endcase
  endtask

  // watch both channels, predict on input, compare on output
  always @(posedge clk) begin
    cmd_word_t want;
    if (!rst_n) begin
      mode = ST_GROUND;
      clear_csi();
      cmd_q.delete();
      errors     = 0;
      words_in   = 0;
      words_out  = 0;
      kinds_seen = '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        words_in++;
        parse_code(in_ch.code);
      end
      if (out_ch.valid && out_ch.ready) begin
        words_out++;
        if (cmd_q.size() == 0) begin
          report("command word with nothing expected, cmd", int'(out_ch.cmd), -1);
        end else begin
          want = cmd_q.pop_front();
          kinds_seen[want.cmd] = 1'b1;
          if (out_ch.cmd !== want.cmd) report("cmd", int'(out_ch.cmd), int'(want.cmd));
          if (out_ch.arg_a !== want.arg_a) report("arg_a", int'(out_ch.arg_a), int'(want.arg_a));
          if (out_ch.arg_b !== want.arg_b) report("arg_b", int'(out_ch.arg_b), int'(want.arg_b));
          if (out_ch.last !== want.last) report("last", int'(out_ch.last), int'(want.last));
        end
      end
    end
    pending <= cmd_q.size();
  end

endmodule

// File: tb/tb_ansi_csi_escape_parser.sv
// testbench top: code word stimulus, result backpressure, watchdog and verdict
module tb_ansi_csi_escape_parser;
  import acep_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int RANDOM_WORDS = 480;
  localparam int CHUNK_WORDS  = 120;

  logic clk;
  logic rst_n;

  acep_in_if  in_ch();
  acep_out_if out_ch();

  int          errors;
  int          pending;
  int          words_in;
  int          words_out;
  logic [11:0] kinds_seen;
  int          idle_cycles;
  int          live_words;

  // code words waiting to be sent
  logic [CODE_W-1:0] code_q[$];

  ansi_csi_escape_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  acep_cmd_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .errors     (errors),
    .pending    (pending),
    .words_in   (words_in),
    .words_out  (words_out),
    .kinds_seen (kinds_seen)
  );

  // clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic put_code(input logic [CODE_W-1:0] c);
    code_q.push_back(c);
    if (c != '0) live_words++;
  endtask

  // one decimal parameter: empty, zero, short, or long enough to saturate
  task automatic add_number();
    int digits;
    if ($urandom_range(0, 15) == 0) put_code('0);
    case ($urandom_range(0, 7))
      0: digits = 0;
      1: digits = $urandom_range(5, 8);
      2: begin
        put_code(CH_DIGIT_LO);
        digits = 0;
      end
      default: digits = $urandom_range(1, 2);
    endcase
    repeat (digits) put_code(CH_DIGIT_LO + CODE_W'($urandom_range(0, 9)));
  endtask

  // one random stretch of terminal text
  task automatic add_random_sequence();
    int kind, n;
    kind = $urandom_range(0, 99);
    if (kind < 25) begin
      // plain text, some full-range units and control codes
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 5))
          0: put_code(CODE_W'($urandom));
          1: put_code(CODE_W'($urandom_range(0, 31)));
          2: put_code(CH_DEL);
          default: put_code(CODE_W'($urandom_range(CH_SPACE, CH_FINAL_HI)));
        endcase
      end
    end else if (kind < 37) begin
      // two-word escapes, some of them dropped
      put_code(CH_ESC);
      case ($urandom_range(0, 3))
        0: put_code(CH_SAVE);
        1: put_code(CH_RESTORE);
        2: put_code(CODE_W'($urandom));
        default: put_code(CH_ESC);
      endcase
    end else if (kind < 85) begin
      // well-formed control sequence with random parameters
      put_code(CH_ESC);
      put_code(CH_LBRACKET);
      case ($urandom_range(0, 9))
        0: n = $urandom_range(14, 20);
        1, 2: n = $urandom_range(4, 8);
        default: n = $urandom_range(0, 3);
      endcase
      for (int i = 0; i < n; i++) begin
        add_number();
        if (i < n - 1) put_code(CH_SEMI);
      end
      if ($urandom_range(0, 6) == 0) begin
        put_code(CODE_W'($urandom_range(CH_FINAL_LO, CH_FINAL_HI)));
      end else begin
        case ($urandom_range(0, 14))
          0: put_code(FIN_CUU);
          1: put_code(FIN_CUD);
          2: put_code(FIN_CUF);
          3: put_code(FIN_CUB);
          4: put_code(FIN_CHA);
          5: put_code(FIN_CUP);
          6: put_code(FIN_ED);
          7: put_code(FIN_EL);
          8: put_code(FIN_SU);
          9: put_code(FIN_SD);
          10: put_code(FIN_VPA);
          11: put_code(FIN_HVP);
          12: put_code(FIN_SGR);
          13: put_code(FIN_SCP);
          default: put_code(FIN_RCP);
        endcase
      end
    end else begin
      // sequence ended by a byte outside digits and finals; the 3A-3F pick can be a separator
      put_code(CH_ESC);
      put_code(CH_LBRACKET);
      add_number();
      case ($urandom_range(0, 4))
        0: put_code(CH_ESC);
        1: put_code(CODE_W'($urandom_range(16'h0020, 16'h002F)));
        2: put_code(CODE_W'($urandom_range(16'h003A, 16'h003F)));
        3: put_code(CODE_W'($urandom_range(16'h007F, 16'hFFFF)));
        default: put_code(CODE_W'($urandom_range(1, 16'h001F)));
      endcase
    end
  endtask

  // hold one word until the parser takes it
  task automatic send_word(input logic [CODE_W-1:0] c);
    in_ch.valid <= 1'b1;
    in_ch.code  <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // send the whole queue in bursts with random gaps
  task automatic send_all();
    int burst;
    while (code_q.size() > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && code_q.size() > 0) begin
        send_word(code_q.pop_front());
        burst--;
      end
      if ($urandom_range(0, 3) != 0) begin
        in_ch.valid <= 1'b0;
        in_ch.code  <= CODE_W'($urandom);
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  // pause until every expected command word has come out
  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // result side backpressure in four random styles
  initial begin
    int style, cyc;
    out_ch.ready <= 1'b0;
    style = 0;
    cyc   = 0;
    forever begin
      @(posedge clk);
      if (cyc % 64 == 0) style = $urandom_range(0, 3);
      case (style)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 1) == 1);
        2: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= (cyc % 5 != 4);
      endcase
      cyc++;
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus and verdict
  initial begin
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.code  <= '0;
    live_words  = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // ground: ignored zero, all-ones print, control codes at both ends
    put_code('0);
    put_code(16'hFFFF);
    put_code(16'h001F);
    put_code(CH_DEL);
    // cursor save and restore, then an escape byte that is dropped
    put_code(CH_ESC);
    put_code(CH_SAVE);
    put_code(CH_ESC);
    put_code(CH_RESTORE);
    put_code(CH_ESC);
    put_code(16'h005A);
    // position with a saturating first number and a zero second one
    put_code(CH_ESC);
    put_code(CH_LBRACKET);
    repeat (6) put_code(CH_DIGIT_HI);
    put_code(CH_SEMI);
    put_code(CH_DIGIT_LO);
    put_code(FIN_CUP);
    // sgr with no parameter
    put_code(CH_ESC);
    put_code(CH_LBRACKET);
    put_code(FIN_SGR);
    // sequence cancelled by a unit above the final range
    put_code(CH_ESC);
    put_code(CH_LBRACKET);
    put_code(CH_DIGIT_LO + 16'd1);
    put_code(16'h8000);
    send_all();
    wait_drained();

    // random text in chunks, draining between them
    repeat (RANDOM_WORDS / CHUNK_WORDS) begin
      live_words = 0;
      while (live_words < CHUNK_WORDS) add_random_sequence();
      send_all();
      wait_drained();
    end

    // tail: give a stray word time to show up
    repeat (8) @(posedge clk);

    $display("run: %0d code words sent, %0d command words checked", words_in, words_out);
    $display("command kinds seen: %0d of 12, mismatches: %0d", $countones(kinds_seen), errors);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
